// ===== design/sfhc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 fold hash chain package
// State encoding and SHA-1 constants shared by the hash chain block.
// ----------------------------------------------------------------------------
package sfhc_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } sfhc_state_t;

  typedef logic [31:0] word_t;

  localparam word_t IV0 = 32'h6745_2301;
  localparam word_t IV1 = 32'hEFCD_AB89;
  localparam word_t IV2 = 32'h98BA_DCFE;
  localparam word_t IV3 = 32'h1032_5476;
  localparam word_t IV4 = 32'hC3D2_E1F0;

  localparam word_t K0 = 32'h5A82_7999;
  localparam word_t K1 = 32'h6ED9_EBA1;
  localparam word_t K2 = 32'h8F1B_BCDC;
  localparam word_t K3 = 32'hCA62_C1D6;

  // Padding word that follows the 8-byte message, and the bit length word.
  localparam word_t PAD_WORD = 32'h8000_0000;
  localparam word_t LEN_WORD = 32'h0000_0040;

  localparam int unsigned ROUNDS    = 80;
  localparam logic [6:0]  LAST_ROUND = 7'(ROUNDS - 1);

  function automatic word_t bswap(input word_t x);
    bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage : sfhc_pkg
`default_nettype wire

// ===== design/sha1_fold_hash_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-1 fold hash chain
// Iterates the one-time-password SHA-1 fold step over a 64-bit chain value.
// ----------------------------------------------------------------------------
// A word on the input carries a 64-bit start value and a fold count. Each fold
// step hashes the value's eight bytes (most significant first) as one padded
// SHA-1 block and folds the 160-bit digest back to 64 bits by XOR of its byte
// groups. Only the low COUNT_BITS bits of the count are used, and a count of
// zero returns the start value. One SHA-1 round unit does all the hashing: a
// fold step runs the SHA-1 rounds one after another and then the fold, and
// the result is shown once the last fold step is done. The block works on one
// word at a time; in_stall stays high from acceptance until the result word
// has been taken on the output.
// ----------------------------------------------------------------------------
module sha1_fold_hash_chain #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [63:0] in_start_value,
  input  wire logic [15:0] in_iteration_count,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [63:0] out_hashed_value
);
  import sfhc_pkg::*;

  // The count port is 16 bits wide, so at most 16 count bits are meaningful.
  localparam int CntW = (COUNT_BITS < 16) ? COUNT_BITS : 16;

  sfhc_state_t state_r, state_nxt;

  logic [CntW-1:0] steps_r, steps_nxt;
  logic [6:0]      round_r, round_nxt;
  logic [63:0]     chain_r, chain_nxt;
  word_t           wv_r   [5];
  word_t           wv_nxt [5];
  word_t           sched_r   [16];
  word_t           sched_nxt [16];

  logic            in_take;
  logic [CntW-1:0] in_count;
  word_t           f_val, k_val, sum_val, sched_new;
  word_t           dig    [5];
  logic [63:0]     fold_val;

  assign in_take  = in_valid && !in_stall;
  assign in_count = in_iteration_count[CntW-1:0];

  // Round function and constant for the current round.
  always_comb begin
    case (round_r) inside
      [7'd0:7'd19]: begin
        f_val = (wv_r[1] & wv_r[2]) | (~wv_r[1] & wv_r[3]);
        k_val = K0;
      end
      [7'd20:7'd39]: begin
        f_val = wv_r[1] ^ wv_r[2] ^ wv_r[3];
        k_val = K1;
      end
      [7'd40:7'd59]: begin
        f_val = (wv_r[1] & wv_r[2]) | (wv_r[1] & wv_r[3]) | (wv_r[2] & wv_r[3]);
        k_val = K2;
      end
      default: begin
        f_val = wv_r[1] ^ wv_r[2] ^ wv_r[3];
        k_val = K3;
      end
    endcase
  end

  // The schedule window holds W[t..t+15]; the word W[t+16] is appended as
  // W[t] leaves, so every tap sits at a fixed place of the shift line.
  assign sched_new = {sched_r[13][30:0] ^ sched_r[8][30:0] ^ sched_r[2][30:0] ^
                      sched_r[0][30:0],
                      sched_r[13][31] ^ sched_r[8][31] ^ sched_r[2][31] ^ sched_r[0][31]};

  assign sum_val = {wv_r[0][26:0], wv_r[0][31:27]} + f_val + wv_r[4] + k_val + sched_r[0];

  // Final digest words and the fold to 64 bits.
  assign dig[0] = IV0 + wv_r[0];
  assign dig[1] = IV1 + wv_r[1];
  assign dig[2] = IV2 + wv_r[2];
  assign dig[3] = IV3 + wv_r[3];
  assign dig[4] = IV4 + wv_r[4];
  assign fold_val = {bswap(dig[4]) ^ bswap(dig[2]) ^ bswap(dig[0]),
                     bswap(dig[3]) ^ bswap(dig[1])};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = (in_count == '0) ? ST_OUT : ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        state_nxt = (steps_r == CntW'(1)) ? ST_OUT : ST_ROUND;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall         = (state_r != ST_IDLE);
    out_valid        = (state_r == ST_OUT);
    out_hashed_value = chain_r;
  end

  // Datapath next values: a new hash block is set up on acceptance and after
  // every fold, the last one included.
  always_comb begin
    logic [63:0] seed;
    logic        load;

    steps_nxt = steps_r;
    round_nxt = round_r;
    chain_nxt = chain_r;
    wv_nxt    = wv_r;
    sched_nxt = sched_r;
    seed      = chain_r;
    load      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          chain_nxt = in_start_value;
          steps_nxt = in_count;
          seed      = in_start_value;
          load      = 1'b1;
        end
      end
      ST_ROUND: begin
        wv_nxt[4] = wv_r[3];
        wv_nxt[3] = wv_r[2];
        wv_nxt[2] = {wv_r[1][1:0], wv_r[1][31:2]};
        wv_nxt[1] = wv_r[0];
        wv_nxt[0] = sum_val;
        for (int j = 0; j < 15; j++) begin
          sched_nxt[j] = sched_r[j+1];
        end
        sched_nxt[15] = sched_new;
        round_nxt = (round_r == LAST_ROUND) ? 7'd0 : round_r + 7'd1;
      end
      ST_FOLD: begin
        chain_nxt = fold_val;
        steps_nxt = steps_r - CntW'(1);
        seed      = fold_val;
        load      = 1'b1;
      end
      default: begin
      end
    endcase

    if (load) begin
      wv_nxt[0] = IV0;
      wv_nxt[1] = IV1;
      wv_nxt[2] = IV2;
      wv_nxt[3] = IV3;
      wv_nxt[4] = IV4;
      for (int j = 0; j < 16; j++) begin
        sched_nxt[j] = '0;
      end
      sched_nxt[0]  = seed[63:32];
      sched_nxt[1]  = seed[31:0];
      sched_nxt[2]  = PAD_WORD;
      sched_nxt[15] = LEN_WORD;
      round_nxt     = 7'd0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      steps_r <= '0;
      round_r <= 7'd0;
    end else begin
      state_r <= state_nxt;
      steps_r <= steps_nxt;
      round_r <= round_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    chain_r <= chain_nxt;
    wv_r    <= wv_nxt;
    sched_r <= sched_nxt;
  end

`ifndef SYNTHESIS
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    round_r <= LAST_ROUND)
    else $error("round counter left the SHA-1 round range");

  a_zero_count_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_count == '0) |=> (out_valid && out_hashed_value == $past(in_start_value)))
    else $error("zero-count word did not pass its value straight through");

  a_last_round_folds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && round_r == LAST_ROUND) |=> (state_r == ST_FOLD))
    else $error("last round was not followed by a fold");

  a_last_fold_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FOLD && steps_r == CntW'(1)) |=> (out_valid && steps_r == '0))
    else $error("final fold did not present the result");

  a_fold_nonzero_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND || state_r == ST_FOLD) |-> (steps_r != '0))
    else $error("hashing with no fold steps left");
`endif

endmodule : sha1_fold_hash_chain
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 fold hash chain testbench
// Drives start values and fold counts into the hash chain and checks every
// result word against an in-bench SHA-1 fold predictor, with random idling on
// both sides of the block.
// ----------------------------------------------------------------------------
module tb_top;

  // The block runs with its full 16-bit count. Fold steps are slow, so the
  // counts are kept short: the random words stay in the low byte, and
  // a few directed words reach into the upper byte of the count port.
  localparam int          CNT_BITS   = 16;
  localparam logic [15:0] CNT_MASK   = 16'((1 << CNT_BITS) - 1);
  localparam int          RAND_WORDS = 1630;
  localparam int          DRAIN_EVERY = 300;

  // SHA-1 initial hash words and round constants.
  localparam logic [31:0] H0_INIT = 32'h6745_2301;
  localparam logic [31:0] H1_INIT = 32'hEFCD_AB89;
  localparam logic [31:0] H2_INIT = 32'h98BA_DCFE;
  localparam logic [31:0] H3_INIT = 32'h1032_5476;
  localparam logic [31:0] H4_INIT = 32'hC3D2_E1F0;
  localparam logic [31:0] RC_CH   = 32'h5A82_7999;
  localparam logic [31:0] RC_PAR1 = 32'h6ED9_EBA1;
  localparam logic [31:0] RC_MAJ  = 32'h8F1B_BCDC;
  localparam logic [31:0] RC_PAR2 = 32'hCA62_C1D6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_start_value = '0;
  logic [15:0] in_iteration_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [63:0] out_hashed_value;

  // Expected chain values, oldest first, and the bookkeeping of the checker.
  logic [63:0] chain_due_q [$];
  int          mismatch_count = 0;
  longint      cycle_count = 0;
  longint      cycle_budget = 0;
  int          recv_hold = 3;
  bit          recv_calm = 1'b0;
  bit          send_calm = 1'b0;

  always #5 clk = ~clk;

  sha1_fold_hash_chain #(
    .COUNT_BITS(CNT_BITS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_start_value    (in_start_value),
    .in_iteration_count(in_iteration_count),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hashed_value  (out_hashed_value)
  );

  // One fold step: SHA-1 over the value's eight bytes as a single padded
  // block, then the 160-bit digest is folded down to 64 bits. Byte j of the
  // result (most significant first) is digest byte 19-j xor byte 11-j, and
  // for the top four bytes also xor byte 3-j.
  function automatic logic [63:0] sha1_fold_step(input logic [63:0] v);
    logic [31:0]  w [0:79];
    logic [31:0]  a, b, c, d, e, f, k, t, x;
    logic [159:0] dig;
    logic [7:0]   bk;
    logic [63:0]  r;
    for (int i = 0; i < 16; i++) w[i] = 32'h0;
    w[0]  = v[63:32];
    w[1]  = v[31:0];
    w[2]  = 32'h8000_0000;
    w[15] = 32'd64;
    for (int i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = H0_INIT;
    b = H1_INIT;
    c = H2_INIT;
    d = H3_INIT;
    e = H4_INIT;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = RC_CH;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = RC_PAR1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RC_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = RC_PAR2;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    dig = {H0_INIT + a, H1_INIT + b, H2_INIT + c, H3_INIT + d, H4_INIT + e};
    r = '0;
    for (int j = 0; j < 8; j++) begin
      bk = dig[159 - 8*(19-j) -: 8] ^ dig[159 - 8*(11-j) -: 8];
      if (j < 4) bk = bk ^ dig[159 - 8*(3-j) -: 8];
      r[63 - 8*j -: 8] = bk;
    end
    return r;
  endfunction

  // The whole chain for one input word. Only the low CNT_BITS bits of the
  // count take effect, and a zero count hands the start value straight back.
  function automatic logic [63:0] fold_chain(input logic [63:0] v, input logic [15:0] cnt);
    logic [63:0] val;
    int          steps;
    val = v;
    steps = int'(cnt & CNT_MASK);
    for (int s = 0; s < steps; s++) val = sha1_fold_step(val);
    return val;
  endfunction

  // Presents one word to the block and returns at the edge that takes it.
  // The sender's gap is drawn per word; with a zero gap in_valid stays high
  // and only the payload changes, so it is never lowered and raised in the
  // same step. The expected chain value is queued at the accepting edge.
  task automatic issue_word(input logic [63:0] v, input logic [15:0] cnt,
                            input logic [63:0] want);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 8);
    if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
    // Room for this word at its slowest: all fold steps, both idle draws and
    // the handshake cycles.
    cycle_budget += 81 * longint'(cnt & CNT_MASK) + 24;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_start_value     <= v;
    in_iteration_count <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chain_due_q.push_back(want);
  endtask

  // Holds the sender back until every queued result has been taken.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (chain_due_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Receiver side. After each taken result a hold length is drawn; it only
  // counts down while a result is waiting, so every result sees its stall.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if ($urandom_range(0, 39) == 0) recv_calm <= ~recv_calm;
      recv_hold = recv_calm ? 0 : $urandom_range(0, 8);
    end else if (out_valid && recv_hold != 0) begin
      recv_hold = recv_hold - 1;
    end
    out_stall <= (recv_hold != 0);
  end

  // Result checker: each taken word is held against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (chain_due_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: hashed_value=%016h", out_hashed_value);
      end else begin
        if (out_hashed_value !== chain_due_q[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("hashed_value mismatch: expected %016h, got %016h",
                     chain_due_q[0], out_hashed_value);
        end
        void'(chain_due_q.pop_front());
      end
    end
  end

  // Watchdog: generous multiple of the slowest correct run for what has
  // been issued so far, plus a fixed allowance for reset and the tail.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 4 * cycle_budget + 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Directed words. Rows with a known result are the ones that can be read
  // off directly: a zero count hands the start value back.
  typedef struct packed {
    logic [63:0] start;
    logic [15:0] count;
    logic        known;
    logic [63:0] want;
  } dir_row_t;

  localparam int DIR_ROWS = 16;

  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{64'h0000_0000_0000_0000, 16'h0000, 1'b1, 64'h0000_0000_0000_0000},
    '{64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
    '{64'h0123_4567_89AB_CDEF, 16'h0000, 1'b1, 64'h0123_4567_89AB_CDEF},
    '{64'h0000_0000_0000_0000, 16'h0001, 1'b0, 64'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 16'h0001, 1'b0, 64'h0},
    '{64'h8000_0000_0000_0000, 16'h0001, 1'b0, 64'h0},
    '{64'h0000_0000_0000_0001, 16'h0002, 1'b0, 64'h0},
    '{64'hDEAD_BEEF_CAFE_F00D, 16'h0003, 1'b0, 64'h0},
    // Counts that reach into the upper byte of the count port, around one
    // more pass-through.
    '{64'h5555_5555_5555_5555, 16'h0100, 1'b0, 64'h0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 16'h0000, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA},
    '{64'h0F0F_0F0F_0F0F_0F0F, 16'h0101, 1'b0, 64'h0},
    // Same start value twice in a row: nothing may carry over.
    '{64'h0000_0000_0000_0000, 16'h0001, 1'b0, 64'h0},
    '{64'h0000_0000_0000_0000, 16'h0002, 1'b0, 64'h0},
    '{64'hF0F0_F0F0_F0F0_F0F0, 16'h00F0, 1'b0, 64'h0},
    // A long chain with every bit of the low count byte set.
    '{64'h1234_5678_9ABC_DEF0, 16'h00FF, 1'b0, 64'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF}
  };

  initial begin
    logic [63:0] want;
    logic [63:0] start;
    logic [63:0] last_chain;
    logic [15:0] cnt;
    logic [7:0]  low_cnt;
    int          pick;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      want = dir_rows[i].known ? dir_rows[i].want
                               : fold_chain(dir_rows[i].start, dir_rows[i].count);
      issue_word(dir_rows[i].start, dir_rows[i].count, want);
    end
    wait_for_drain();

    // Random part. Most words carry short counts so the run stays short;
    // a few go up to 255. Start values are random, extreme, or the previous
    // chain value, which is how a hash chain is really used.
    last_chain = 64'h0;
    for (int n = 0; n < RAND_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      start = {$urandom, $urandom};
      else if (pick < 80) start = last_chain;
      else if (pick < 85) start = 64'h0;
      else if (pick < 90) start = '1;
      else                start = 64'h1 << $urandom_range(0, 63);

      pick = $urandom_range(0, 99);
      if (pick < 1)       low_cnt = 8'($urandom_range(0, 255));
      else if (pick < 10) low_cnt = 8'($urandom_range(4, 12));
      else                low_cnt = 8'($urandom_range(0, 3));
      cnt = {8'h00, low_cnt};

      want = fold_chain(start, cnt);
      issue_word(start, cnt, want);
      last_chain = want;
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) wait_for_drain();
    end
    in_valid <= 1'b0;

    while (chain_due_q.size() != 0) @(posedge clk);
    // Let any stray word show up before the verdict.
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
